FILE: hdl/ubin_pkg.sv
// ubin_pkg: request and result types, function and result codes for the
// uniform grid particle binner. No dependencies.
`default_nettype none

package ubin_pkg;

  localparam int POS_W = 32;
  localparam int DIM_W = 7;
  localparam logic [31:0] CELL_SIZE_RST = 32'h0001_0000;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_CELL = 2'd1;
  localparam logic [1:0] FUNC_NBHD = 2'd2;

  localparam logic [2:0] KIND_BUILT     = 3'd0;
  localparam logic [2:0] KIND_NOT_BUILT = 3'd1;
  localparam logic [2:0] KIND_TOO_LARGE = 3'd2;
  localparam logic [2:0] KIND_INDEX     = 3'd3;
  localparam logic [2:0] KIND_NONE      = 3'd4;

  typedef struct packed {
    logic [1:0]               func;
    logic                     is_gas;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic                     load_last;
    logic signed [7:0]        cell_x;
    logic signed [7:0]        cell_y;
    logic signed [7:0]        cell_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       result_kind;
    logic [9:0]       particle_index;
    logic [DIM_W-1:0] grid_x_count;
    logic [DIM_W-1:0] grid_y_count;
    logic [DIM_W-1:0] grid_z_count;
    logic             truncated;
    logic             last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/ubin_div.sv
// ubin_div: shared restoring divider, one quotient bit per cycle.
// Standalone; used by the binner top level for dimensions and cell coords.
`default_nettype none

module ubin_div #(
  parameter int W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic              rem_nz_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W:0]       rem_q, rem_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic [W:0]       rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o   = done_q;
  assign quot_o   = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

`default_nettype wire

FILE: hdl/uniform_grid_particle_binner.sv
// uniform_grid_particle_binner: top level, sequencer, particle and cell memories.
// Depends on ubin_pkg and ubin_div.
//
//   channel  direction  handshake                payload
//   in       request    in_valid_i / in_stall_o  ubin_pkg::in_item_t
//   out      result     out_valid_o/out_stall_i  ubin_pkg::out_item_t
//   cfg      write      cfg_valid_i/cfg_ready_o  cell_size, 32 bits
//
// A load without load_last leaves the sequencer idle. A build computes the dimensions,
// clears the cell counts, bins each gas particle (three passes of the shared divider),
// prefix-sums the counts and sorts the binned particles. A query reads each visited
// cell and copies each index found, then emits the results.
// Reset clears control only; memories are rewritten by each build.
// in_stall_o is high whenever the sequencer is busy; a held result only stalls S_RES/S_EWR.
`default_nettype none

module uniform_grid_particle_binner #(
  parameter int MAX_PARTICLES = 1024,
  parameter int MAX_CELLS     = 4096,
  parameter int MAX_DIM       = 64,
  parameter int RESULT_CAP    = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ubin_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ubin_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [31:0]         cfg_data_i
);

  localparam int PW  = $clog2(MAX_PARTICLES);
  localparam int CW  = $clog2(MAX_CELLS);
  localparam int BW  = (RESULT_CAP > 1) ? $clog2(RESULT_CAP) : 1;
  localparam int RW  = $clog2(RESULT_CAP + 1);
  localparam int DW  = ubin_pkg::DIM_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_B0    = 5'd1;
  localparam logic [4:0] S_BDIV  = 5'd2;
  localparam logic [4:0] S_BDW   = 5'd3;
  localparam logic [4:0] S_BMUL1 = 5'd4;
  localparam logic [4:0] S_BMUL2 = 5'd5;
  localparam logic [4:0] S_CLR   = 5'd6;
  localparam logic [4:0] S_HRD   = 5'd7;
  localparam logic [4:0] S_HDAT  = 5'd8;
  localparam logic [4:0] S_HDIV  = 5'd9;
  localparam logic [4:0] S_HDW   = 5'd10;
  localparam logic [4:0] S_HIDX  = 5'd11;
  localparam logic [4:0] S_HFRD  = 5'd12;
  localparam logic [4:0] S_HFWR  = 5'd13;
  localparam logic [4:0] S_PRD   = 5'd14;
  localparam logic [4:0] S_PWR   = 5'd15;
  localparam logic [4:0] S_SRD   = 5'd16;
  localparam logic [4:0] S_SDAT  = 5'd17;
  localparam logic [4:0] S_SWR   = 5'd18;
  localparam logic [4:0] S_QCELL = 5'd19;
  localparam logic [4:0] S_QFRD  = 5'd20;
  localparam logic [4:0] S_QFDAT = 5'd21;
  localparam logic [4:0] S_QJ    = 5'd22;
  localparam logic [4:0] S_QJWR  = 5'd23;
  localparam logic [4:0] S_ERD   = 5'd24;
  localparam logic [4:0] S_EWR   = 5'd25;
  localparam logic [4:0] S_RES   = 5'd26;
  localparam logic [4:0] S_BFIN  = 5'd27;
  localparam logic [4:0] S_QEND  = 5'd28;

  typedef struct packed {
    logic              gas;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } stored_t;

  // control and loop registers
  logic [4:0]         state_q, state_d;
  logic [31:0]        cell_size_q, cell_size_d;
  logic [PW:0]        cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               gas_q, gas_d;
  logic signed [31:0] lo_q [3];
  logic signed [31:0] lo_d [3];
  logic signed [31:0] hi_q [3];
  logic signed [31:0] hi_d [3];
  logic [DW-1:0]      nd_q [3];
  logic [DW-1:0]      nd_d [3];
  logic [DW-1:0]      dim_q [3];
  logic [DW-1:0]      dim_d [3];
  logic [DW-1:0]      cc_q [3];
  logic [DW-1:0]      cc_d [3];
  logic [13:0]        dxdy_q, dxdy_d;
  logic [CW:0]        total_q, total_d;
  logic               big_q, big_d;
  logic               gvalid_q, gvalid_d;
  logic [1:0]         d_q, d_d;
  logic [PW:0]        i_q, i_d;
  logic [CW:0]        f_q, f_d;
  logic [PW:0]        run_q, run_d;
  logic [CW-1:0]      hf_q, hf_d;
  logic signed [7:0]  bx_q, bx_d, by_q, by_d, bz_q, bz_d;
  logic               rad_q, rad_d;
  logic [1:0]         ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [CW-1:0]      qf_q, qf_d;
  logic [PW:0]        qn_q, qn_d;
  logic [PW:0]        qs_q, qs_d;
  logic [PW:0]        j_q, j_d;
  logic [RW-1:0]      n_q, n_d;
  logic [RW-1:0]      k_q, k_d;
  logic               trunc_q, trunc_d;
  ubin_pkg::out_item_t res_q, res_d;
  logic               out_valid_q, out_valid_d;
  ubin_pkg::out_item_t out_q, out_d;

  // memories
  stored_t       pos_mem   [MAX_PARTICLES];
  logic [CW:0]   home_mem  [MAX_PARTICLES];
  logic [PW:0]   fill_mem  [MAX_CELLS];
  logic [PW:0]   start_mem [MAX_CELLS];
  logic [PW-1:0] sort_mem  [MAX_PARTICLES];
  logic [PW-1:0] buf_mem   [RESULT_CAP];

  stored_t       pos_rd_q;
  logic [CW:0]   home_rd_q;
  logic [PW:0]   fill_rd_q, start_rd_q;
  logic [PW-1:0] sort_rd_q, buf_rd_q;

  logic          pos_we, pos_re;
  logic [PW-1:0] pos_wa, pos_ra;
  stored_t       pos_wd;
  logic          home_we, home_re;
  logic [PW-1:0] home_wa, home_ra;
  logic [CW:0]   home_wd;
  logic          fill_we, fill_re;
  logic [CW-1:0] fill_wa, fill_ra;
  logic [PW:0]   fill_wd;
  logic          start_we, start_re;
  logic [CW-1:0] start_wa, start_ra;
  logic [PW:0]   start_wd;
  logic          sort_we, sort_re;
  logic [PW-1:0] sort_wa, sort_ra;
  logic [PW-1:0] sort_wd;
  logic          buf_we, buf_re;
  logic [BW-1:0] buf_wa, buf_ra;
  logic [PW-1:0] buf_wd;

  // divider
  logic          div_start, div_done, div_nz;
  logic [31:0]   div_a, div_q;

  // combinational helpers
  logic               in_acc, out_free;
  logic               fail, adv, clr_set;
  logic [2:0]         fail_kind;
  logic [33:0]        dimv;
  logic [20:0]        prod;
  logic [21:0]        hsum, qsum;
  logic signed [9:0]  qx, qy, qz;
  logic               q_in;
  logic signed [31:0] hcoord;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign div_start = (state_q == S_BDIV) || (state_q == S_HDIV);

  always_comb begin
    case (d_q)
      2'd0:    hcoord = pos_rd_q.x;
      2'd1:    hcoord = pos_rd_q.y;
      default: hcoord = pos_rd_q.z;
    endcase
    if (state_q == S_BDIV) begin
      div_a = 32'(hi_q[d_q] - lo_q[d_q]);
    end else begin
      div_a = 32'(hcoord - lo_q[d_q]);
    end
  end

  ubin_div #(
    .W (32)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (cell_size_q),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_nz_o   (div_nz)
  );

  assign dimv = 34'(div_q) + 34'(div_nz) + 34'd4;
  assign prod = 21'(dxdy_q) * 21'(nd_q[2]);
  assign hsum = 22'(cc_q[0]) + 22'(14'(cc_q[1]) * 14'(nd_q[0]))
              + 22'(21'(cc_q[2]) * 21'(dxdy_q));

  assign qx = 10'(bx_q) + $signed({8'd0, ox_q}) - 10'sd1;
  assign qy = 10'(by_q) + $signed({8'd0, oy_q}) - 10'sd1;
  assign qz = 10'(bz_q) + $signed({8'd0, oz_q}) - 10'sd1;
  assign q_in = !qx[9] && !qy[9] && !qz[9] &&
                (qx[8:0] < 9'(dim_q[0])) && (qy[8:0] < 9'(dim_q[1])) &&
                (qz[8:0] < 9'(dim_q[2]));
  assign qsum = 22'(qx[DW-1:0]) + 22'(14'(qy[DW-1:0]) * 14'(dim_q[0]))
              + 22'(21'(qz[DW-1:0]) * 21'(dxdy_q));

  always_comb begin
    state_d     = state_q;
    cell_size_d = cell_size_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    gas_d       = gas_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    nd_d        = nd_q;
    dim_d       = dim_q;
    cc_d        = cc_q;
    dxdy_d      = dxdy_q;
    total_d     = total_q;
    big_d       = big_q;
    gvalid_d    = gvalid_q;
    d_d         = d_q;
    i_d         = i_q;
    f_d         = f_q;
    run_d       = run_q;
    hf_d        = hf_q;
    bx_d        = bx_q;
    by_d        = by_q;
    bz_d        = bz_q;
    rad_d       = rad_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    oz_d        = oz_q;
    qf_d        = qf_q;
    qn_d        = qn_q;
    qs_d        = qs_q;
    j_d         = j_q;
    n_d         = n_q;
    k_d         = k_q;
    trunc_d     = trunc_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    fail      = 1'b0;
    fail_kind = ubin_pkg::KIND_NOT_BUILT;
    adv       = 1'b0;
    clr_set   = 1'b0;

    pos_we   = 1'b0;  pos_re   = 1'b0;
    pos_wa   = cnt_q[PW-1:0];
    pos_ra   = i_q[PW-1:0];
    pos_wd   = '{gas: in_data_i.is_gas, x: in_data_i.pos_x, y: in_data_i.pos_y,
                 z: in_data_i.pos_z};
    home_we  = 1'b0;  home_re  = 1'b0;
    home_wa  = i_q[PW-1:0];
    home_ra  = i_q[PW-1:0];
    home_wd  = '0;
    fill_we  = 1'b0;  fill_re  = 1'b0;
    fill_wa  = f_q[CW-1:0];
    fill_ra  = f_q[CW-1:0];
    fill_wd  = '0;
    start_we = 1'b0;  start_re = 1'b0;
    start_wa = f_q[CW-1:0];
    start_ra = home_rd_q[CW-1:0];
    start_wd = run_q;
    sort_we  = 1'b0;  sort_re  = 1'b0;
    sort_wa  = PW'(start_rd_q + fill_rd_q);
    sort_ra  = PW'(qs_q + j_q);
    sort_wd  = i_q[PW-1:0];
    buf_we   = 1'b0;  buf_re   = 1'b0;
    buf_wa   = n_q[BW-1:0];
    buf_ra   = k_q[BW-1:0];
    buf_wd   = sort_rd_q;

    if (cfg_valid_i) begin
      cell_size_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.func)
            ubin_pkg::FUNC_LOAD: begin
              if (cnt_q < (PW+1)'(MAX_PARTICLES)) begin
                pos_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                if (in_data_i.is_gas) begin
                  gas_d = 1'b1;
                  if (in_data_i.pos_x < lo_q[0]) lo_d[0] = in_data_i.pos_x;
                  if (in_data_i.pos_y < lo_q[1]) lo_d[1] = in_data_i.pos_y;
                  if (in_data_i.pos_z < lo_q[2]) lo_d[2] = in_data_i.pos_z;
                  if (in_data_i.pos_x > hi_q[0]) hi_d[0] = in_data_i.pos_x;
                  if (in_data_i.pos_y > hi_q[1]) hi_d[1] = in_data_i.pos_y;
                  if (in_data_i.pos_z > hi_q[2]) hi_d[2] = in_data_i.pos_z;
                end
              end else begin
                ovf_d = 1'b1;
              end
              if (in_data_i.load_last) state_d = S_B0;
            end
            ubin_pkg::FUNC_CELL, ubin_pkg::FUNC_NBHD: begin
              bx_d    = in_data_i.cell_x;
              by_d    = in_data_i.cell_y;
              bz_d    = in_data_i.cell_z;
              rad_d   = (in_data_i.func == ubin_pkg::FUNC_NBHD);
              ox_d    = (in_data_i.func == ubin_pkg::FUNC_NBHD) ? 2'd0 : 2'd1;
              oy_d    = (in_data_i.func == ubin_pkg::FUNC_NBHD) ? 2'd0 : 2'd1;
              oz_d    = (in_data_i.func == ubin_pkg::FUNC_NBHD) ? 2'd0 : 2'd1;
              n_d     = '0;
              trunc_d = 1'b0;
              state_d = gvalid_q ? S_QCELL : S_QEND;
            end
            default: ;
          endcase
        end
      end

      S_B0: begin
        big_d = 1'b0;
        d_d   = 2'd0;
        if (cell_size_q == 32'd0 || !gas_q) begin
          fail = 1'b1;
        end else begin
          state_d = S_BDIV;
        end
      end

      S_BDIV: state_d = S_BDW;

      S_BDW: begin
        if (div_done) begin
          big_d     = big_q | (dimv > 34'(MAX_DIM));
          nd_d[d_q] = dimv[DW-1:0];
          if (d_q == 2'd2) begin
            if (big_q | (dimv > 34'(MAX_DIM))) begin
              fail      = 1'b1;
              fail_kind = ubin_pkg::KIND_TOO_LARGE;
            end else begin
              state_d = S_BMUL1;
            end
          end else begin
            d_d     = d_q + 1'b1;
            state_d = S_BDIV;
          end
        end
      end

      S_BMUL1: begin
        dxdy_d  = 14'(nd_q[0]) * 14'(nd_q[1]);
        state_d = S_BMUL2;
      end

      S_BMUL2: begin
        if (prod > 21'(MAX_CELLS)) begin
          fail      = 1'b1;
          fail_kind = ubin_pkg::KIND_TOO_LARGE;
        end else begin
          total_d = (CW+1)'(prod);
          f_d     = '0;
          state_d = S_CLR;
        end
      end

      S_CLR: begin
        if (f_q == total_q) begin
          i_d     = '0;
          state_d = S_HRD;
        end else begin
          fill_we = 1'b1;
          f_d     = f_q + 1'b1;
        end
      end

      S_HRD: begin
        if (i_q == cnt_q) begin
          f_d     = '0;
          run_d   = '0;
          state_d = S_PRD;
        end else begin
          pos_re  = 1'b1;
          state_d = S_HDAT;
        end
      end

      S_HDAT: begin
        d_d = 2'd0;
        if (!pos_rd_q.gas) begin
          home_we = 1'b1;
          i_d     = i_q + 1'b1;
          state_d = S_HRD;
        end else begin
          state_d = S_HDIV;
        end
      end

      S_HDIV: state_d = S_HDW;

      S_HDW: begin
        if (div_done) begin
          cc_d[d_q] = div_q[DW-1:0] + DW'(2);
          if (d_q == 2'd2) begin
            state_d = S_HIDX;
          end else begin
            d_d     = d_q + 1'b1;
            state_d = S_HDIV;
          end
        end
      end

      S_HIDX: begin
        hf_d    = hsum[CW-1:0];
        state_d = S_HFRD;
      end

      S_HFRD: begin
        fill_re = 1'b1;
        fill_ra = hf_q;
        state_d = S_HFWR;
      end

      S_HFWR: begin
        fill_we = 1'b1;
        fill_wa = hf_q;
        fill_wd = fill_rd_q + 1'b1;
        home_we = 1'b1;
        home_wd = {1'b1, hf_q};
        i_d     = i_q + 1'b1;
        state_d = S_HRD;
      end

      S_PRD: begin
        if (f_q == total_q) begin
          i_d     = '0;
          state_d = S_SRD;
        end else begin
          fill_re = 1'b1;
          state_d = S_PWR;
        end
      end

      S_PWR: begin
        start_we = 1'b1;
        fill_we  = 1'b1;
        run_d    = run_q + fill_rd_q;
        f_d      = f_q + 1'b1;
        state_d  = S_PRD;
      end

      S_SRD: begin
        if (i_q == cnt_q) begin
          state_d = S_BFIN;
        end else begin
          home_re = 1'b1;
          state_d = S_SDAT;
        end
      end

      S_SDAT: begin
        if (home_rd_q[CW]) begin
          fill_re  = 1'b1;
          fill_ra  = home_rd_q[CW-1:0];
          start_re = 1'b1;
          state_d  = S_SWR;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SRD;
        end
      end

      S_SWR: begin
        sort_we = 1'b1;
        fill_we = 1'b1;
        fill_wa = home_rd_q[CW-1:0];
        fill_wd = fill_rd_q + 1'b1;
        i_d     = i_q + 1'b1;
        state_d = S_SRD;
      end

      S_BFIN: begin
        gvalid_d = 1'b1;
        dim_d    = nd_q;
        res_d    = '{result_kind: ubin_pkg::KIND_BUILT, particle_index: '0,
                     grid_x_count: nd_q[0], grid_y_count: nd_q[1],
                     grid_z_count: nd_q[2], truncated: ovf_q, last: 1'b1};
        clr_set  = 1'b1;
        state_d  = S_RES;
      end

      S_QCELL: begin
        if (q_in) begin
          qf_d    = qsum[CW-1:0];
          state_d = S_QFRD;
        end else begin
          adv = 1'b1;
        end
      end

      S_QFRD: begin
        fill_re  = 1'b1;
        fill_ra  = qf_q;
        start_re = 1'b1;
        start_ra = qf_q;
        state_d  = S_QFDAT;
      end

      S_QFDAT: begin
        qn_d    = fill_rd_q;
        qs_d    = start_rd_q;
        j_d     = '0;
        state_d = S_QJ;
      end

      S_QJ: begin
        if (j_q == qn_q) begin
          adv = 1'b1;
        end else if (n_q == RW'(RESULT_CAP)) begin
          trunc_d = 1'b1;
          adv     = 1'b1;
        end else begin
          sort_re = 1'b1;
          state_d = S_QJWR;
        end
      end

      S_QJWR: begin
        buf_we  = 1'b1;
        n_d     = n_q + 1'b1;
        j_d     = j_q + 1'b1;
        state_d = S_QJ;
      end

      S_QEND: begin
        if (n_q == '0) begin
          res_d   = '{result_kind: ubin_pkg::KIND_NONE, particle_index: '0,
                      grid_x_count: dim_q[0], grid_y_count: dim_q[1],
                      grid_z_count: dim_q[2], truncated: 1'b0, last: 1'b1};
          state_d = S_RES;
        end else begin
          k_d     = '0;
          state_d = S_ERD;
        end
      end

      S_ERD: begin
        buf_re  = 1'b1;
        state_d = S_EWR;
      end

      S_EWR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{result_kind: ubin_pkg::KIND_INDEX, particle_index: 10'(buf_rd_q),
                    grid_x_count: dim_q[0], grid_y_count: dim_q[1],
                    grid_z_count: dim_q[2], truncated: trunc_q,
                    last: (k_q + 1'b1 == n_q)};
          k_d     = k_q + 1'b1;
          state_d = (k_q + 1'b1 == n_q) ? S_IDLE : S_ERD;
        end
      end

      S_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (fail) begin
      gvalid_d = 1'b0;
      dim_d    = '{default: '0};
      res_d    = '{result_kind: fail_kind, particle_index: '0, grid_x_count: '0,
                   grid_y_count: '0, grid_z_count: '0, truncated: ovf_q, last: 1'b1};
      clr_set  = 1'b1;
      state_d  = S_RES;
    end

    if (clr_set) begin
      cnt_d = '0;
      ovf_d = 1'b0;
      gas_d = 1'b0;
      lo_d  = '{default: 32'sh7FFF_FFFF};
      hi_d  = '{default: 32'sh8000_0000};
    end

    // neighbourhood walk: x fastest, then y, then z
    if (adv) begin
      state_d = S_QCELL;
      if (rad_q && ox_q != 2'd2) begin
        ox_d = ox_q + 1'b1;
      end else begin
        ox_d = rad_q ? 2'd0 : 2'd1;
        if (rad_q && oy_q != 2'd2) begin
          oy_d = oy_q + 1'b1;
        end else begin
          oy_d = rad_q ? 2'd0 : 2'd1;
          if (rad_q && oz_q != 2'd2) begin
            oz_d = oz_q + 1'b1;
          end else begin
            state_d = S_QEND;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cell_size_q <= ubin_pkg::CELL_SIZE_RST;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      gas_q       <= 1'b0;
      lo_q        <= '{default: 32'sh7FFF_FFFF};
      hi_q        <= '{default: 32'sh8000_0000};
      dim_q       <= '{default: '0};
      gvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cell_size_q <= cell_size_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      gas_q       <= gas_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      dim_q       <= dim_d;
      gvalid_q    <= gvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nd_q    <= nd_d;
    cc_q    <= cc_d;
    dxdy_q  <= dxdy_d;
    total_q <= total_d;
    big_q   <= big_d;
    d_q     <= d_d;
    i_q     <= i_d;
    f_q     <= f_d;
    run_q   <= run_d;
    hf_q    <= hf_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    bz_q    <= bz_d;
    rad_q   <= rad_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oz_q    <= oz_d;
    qf_q    <= qf_d;
    qn_q    <= qn_d;
    qs_q    <= qs_d;
    j_q     <= j_d;
    n_q     <= n_d;
    k_q     <= k_d;
    trunc_q <= trunc_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (pos_re) pos_rd_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk_i) begin
    if (home_we) home_mem[home_wa] <= home_wd;
    if (home_re) home_rd_q <= home_mem[home_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (fill_re) fill_rd_q <= fill_mem[fill_ra];
  end

  always_ff @(posedge clk_i) begin
    if (start_we) start_mem[start_wa] <= start_wd;
    if (start_re) start_rd_q <= start_mem[start_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sort_we) sort_mem[sort_wa] <= sort_wd;
    if (sort_re) sort_rd_q <= sort_mem[sort_ra];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    if (buf_re) buf_rd_q <= buf_mem[buf_ra];
  end

endmodule

`default_nettype wire
